// ----- hdl/fifo_lifo_heap_trace_classifier_top_defines.svh -----
// Assertion macros for the trace classifier.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef FIFO_LIFO_HEAP_TRACE_CLASSIFIER_TOP_DEFINES_SVH
`define FIFO_LIFO_HEAP_TRACE_CLASSIFIER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define TLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tlc assertion failed");
`define TLC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tlc assertion failed after reset");
`else
`define TLC_ASSERT(lbl, prop)
`define TLC_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- hdl/tlc_pkg.sv -----
// Shared types and constants for the trace classifier.
// No dependencies.
`default_nettype none
package tlc_pkg;
  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [IDX_W-1:0]             idx_t;

  typedef enum logic [2:0] {
    V_IMPOSSIBLE = 3'd0,
    V_QUEUE      = 3'd1,
    V_STACK      = 3'd2,
    V_PRIORITY   = 3'd3,
    V_NOT_SURE   = 3'd4
  } verdict_t;

  typedef struct packed {
    data_t key;
    cnt_t  fifo_cnt;
    cnt_t  heap_cnt;
    logic  push_f;
    logic  push_l;
    logic  push_h;
    logic  pop_f;
    logic  pop_l;
    logic  pop_h;
  } cell_ctrl_t;
endpackage
`default_nettype wire

// ----- hdl/tlc_ifs.sv -----
// Channel interfaces for the trace classifier: operation beats in, result beats out.
// Depends on nothing; widths are the fixed field widths.
`default_nettype none
interface tlc_op_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] value;
  logic               last;
  modport source (output valid, action, value, last, input ready);
  modport sink   (input valid, action, value, last, output ready);
endinterface

interface tlc_res_if;
  logic       valid;
  logic       ready;
  logic       fifo_ok;
  logic       lifo_ok;
  logic       heap_ok;
  logic [2:0] verdict;
  logic       overflow;
  logic       case_end;
  modport source (output valid, fifo_ok, lifo_ok, heap_ok, verdict, overflow, case_end,
                  input ready);
  modport sink   (input valid, fifo_ok, lifo_ok, heap_ok, verdict, overflow, case_end,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/tlc_cell.sv -----
// One storage cell: holds one queue, one stack and one sorted heap entry.
// Depends on tlc_pkg.
`default_nettype none
module tlc_cell (
  input  wire                  clk,
  input  tlc_pkg::cell_ctrl_t  ctrl,
  input  tlc_pkg::idx_t        idx,
  input  tlc_pkg::data_t       left_l,
  input  tlc_pkg::data_t       left_h,
  input  wire                  left_ge,
  input  tlc_pkg::data_t       right_f,
  input  tlc_pkg::data_t       right_l,
  input  tlc_pkg::data_t       right_h,
  output tlc_pkg::data_t       f,
  output tlc_pkg::data_t       l,
  output tlc_pkg::data_t       h,
  output logic                 ge
);
  import tlc_pkg::*;

  logic  occ;
  data_t h_ins;

  assign occ   = cnt_t'(idx) < ctrl.heap_cnt;
  assign ge    = occ && (h >= ctrl.key);
  assign h_ins = ge ? h : (left_ge ? ctrl.key : left_h);

  always_ff @(posedge clk) begin
    if (ctrl.pop_f) begin
      f <= right_f;
    end else if (ctrl.push_f && (cnt_t'(idx) == ctrl.fifo_cnt)) begin
      f <= ctrl.key;
    end
    if (ctrl.pop_l) begin
      l <= right_l;
    end else if (ctrl.push_l) begin
      l <= left_l;
    end
    if (ctrl.pop_h) begin
      h <= right_h;
    end else if (ctrl.push_h) begin
      h <= h_ins;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/fifo_lifo_heap_trace_classifier_top.sv -----
// Trace classifier top: control, counts, flags and the row of storage cells.
// Depends on tlc_pkg, tlc_ifs, tlc_cell and the defines header.
// Result: registered on the clock edge that accepts the operation beat.
// Throughput: one beat per cycle unless rsp stalls; a push or pop is one row update.
// Reset: counts, overflow, result valid clear, flags set at once; cells need no clear.
// A beat marked last returns the same control state for the next case.
`default_nettype none
`include "fifo_lifo_heap_trace_classifier_top_defines.svh"
module fifo_lifo_heap_trace_classifier_top (
  input  wire       clk,
  input  wire       rst,
  tlc_op_if.sink    req,
  tlc_res_if.source rsp
);
  import tlc_pkg::*;

  data_t fq [DEPTH];
  data_t lq [DEPTH];
  data_t hq [DEPTH];
  logic  geq [DEPTH];

  cnt_t       fifo_cnt, lifo_cnt, heap_cnt;
  logic [2:0] flags;
  logic       ovf;
  logic       out_valid;

  logic       accept;
  data_t      key;
  cell_ctrl_t ctrl;
  logic [2:0] flags_next;
  logic       ovf_next;
  verdict_t   verdict_next;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign key       = data_t'(req.value);

  always_comb begin
    ctrl          = '0;
    ctrl.key      = key;
    ctrl.fifo_cnt = fifo_cnt;
    ctrl.heap_cnt = heap_cnt;
    flags_next    = flags;
    ovf_next      = ovf;
    if (accept && !req.action) begin
      if (flags[0]) begin
        if (fifo_cnt == cnt_t'(DEPTH)) ovf_next = 1'b1;
        else ctrl.push_f = 1'b1;
      end
      if (flags[1]) begin
        if (lifo_cnt == cnt_t'(DEPTH)) ovf_next = 1'b1;
        else ctrl.push_l = 1'b1;
      end
      if (flags[2]) begin
        if (heap_cnt == cnt_t'(DEPTH)) ovf_next = 1'b1;
        else ctrl.push_h = 1'b1;
      end
    end else if (accept) begin
      if (flags[0]) begin
        if (fifo_cnt == '0 || fq[0] != key) flags_next[0] = 1'b0;
        else ctrl.pop_f = 1'b1;
      end
      if (flags[1]) begin
        if (lifo_cnt == '0 || lq[0] != key) flags_next[1] = 1'b0;
        else ctrl.pop_l = 1'b1;
      end
      if (flags[2]) begin
        if (heap_cnt == '0 || hq[0] != key) flags_next[2] = 1'b0;
        else ctrl.pop_h = 1'b1;
      end
    end
    case (flags_next)
      3'b000:  verdict_next = V_IMPOSSIBLE;
      3'b001:  verdict_next = V_QUEUE;
      3'b010:  verdict_next = V_STACK;
      3'b100:  verdict_next = V_PRIORITY;
      default: verdict_next = V_NOT_SURE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_cnt  <= '0;
      lifo_cnt  <= '0;
      heap_cnt  <= '0;
      flags     <= 3'b111;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready && !accept) out_valid <= 1'b0;
      if (accept) begin
        out_valid <= 1'b1;
        if (req.last) begin
          fifo_cnt <= '0;
          lifo_cnt <= '0;
          heap_cnt <= '0;
          flags    <= 3'b111;
          ovf      <= 1'b0;
        end else begin
          flags <= flags_next;
          ovf   <= ovf_next;
          if (ctrl.push_f) fifo_cnt <= fifo_cnt + 1'b1;
          if (ctrl.pop_f)  fifo_cnt <= fifo_cnt - 1'b1;
          if (ctrl.push_l) lifo_cnt <= lifo_cnt + 1'b1;
          if (ctrl.pop_l)  lifo_cnt <= lifo_cnt - 1'b1;
          if (ctrl.push_h) heap_cnt <= heap_cnt + 1'b1;
          if (ctrl.pop_h)  heap_cnt <= heap_cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.fifo_ok  <= flags_next[0];
      rsp.lifo_ok  <= flags_next[1];
      rsp.heap_ok  <= flags_next[2];
      rsp.verdict  <= verdict_next;
      rsp.overflow <= ovf_next;
      rsp.case_end <= req.last;
    end
  end
  assign rsp.valid = out_valid;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    data_t ll, lh, rf, rl, rh;
    logic  lg;
    if (g == 0) begin : g_first
      assign ll = key;
      assign lh = key;
      assign lg = 1'b1;
    end else begin : g_mid
      assign ll = lq[g-1];
      assign lh = hq[g-1];
      assign lg = geq[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign rf = fq[g];
      assign rl = lq[g];
      assign rh = hq[g];
    end else begin : g_inner
      assign rf = fq[g+1];
      assign rl = lq[g+1];
      assign rh = hq[g+1];
    end
    tlc_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .idx     (idx_t'(g)),
      .left_l  (ll),
      .left_h  (lh),
      .left_ge (lg),
      .right_f (rf),
      .right_l (rl),
      .right_h (rh),
      .f       (fq[g]),
      .l       (lq[g]),
      .h       (hq[g]),
      .ge      (geq[g])
    );
  end

  `TLC_ASSERT(a_cnt_range,
    (fifo_cnt <= cnt_t'(DEPTH)) && (lifo_cnt <= cnt_t'(DEPTH)) && (heap_cnt <= cnt_t'(DEPTH)))
  `TLC_ASSERT(a_last_clears, (accept && req.last) |=>
    (fifo_cnt == '0 && lifo_cnt == '0 && heap_cnt == '0 && flags == 3'b111 && !ovf))
  `TLC_ASSERT(a_flag_sticky, (!flags[0] && !(accept && req.last)) |=> !flags[0])
  `TLC_ASSERT_RST(a_rst_state, rst |=> (flags == 3'b111 && !out_valid && !ovf))
endmodule
`default_nettype wire

// ----- test/tlc_checker.sv -----
// Result checker for the trace classifier: watches the operation and result channels,
// predicts every result beat from the accepted operations and compares field by field.
// Depends on tlc_pkg and tlc_ifs.
`timescale 1ns / 100ps
module tlc_checker (
  input  wire  clk,
  input  wire  rst,
  tlc_op_if    req,
  tlc_res_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   result_count,
  output int   overflow_cases
);
  import tlc_pkg::*;

  typedef struct packed {
    logic     fifo_ok;
    logic     lifo_ok;
    logic     heap_ok;
    verdict_t verdict;
    logic     overflow;
    logic     case_end;
  } trace_result_t;

  data_t fifo_mem [DEPTH];
  data_t lifo_mem [DEPTH];
  data_t heap_mem [DEPTH];
  int    fifo_head, fifo_cnt, lifo_cnt, heap_cnt;
  logic  alive_f, alive_l, alive_h, ovf;

  trace_result_t expected_results[$];

  task automatic clear_trace();
    fifo_head = 0; fifo_cnt = 0; lifo_cnt = 0; heap_cnt = 0;
    alive_f = 1; alive_l = 1; alive_h = 1; ovf = 0;
  endtask

  task automatic heap_insert(data_t k);
    int i, p;
    i = heap_cnt;
    heap_cnt++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_mem[p] >= k) break;
      heap_mem[i] = heap_mem[p];
      i = p;
    end
    heap_mem[i] = k;
  endtask

  task automatic heap_remove_top();
    data_t k;
    int    i, c;
    i = 0;
    heap_cnt--;
    if (heap_cnt != 0) begin
      k = heap_mem[heap_cnt];
      forever begin
        c = 2 * i + 1;
        if (c >= heap_cnt) break;
        if (c + 1 < heap_cnt && heap_mem[c + 1] > heap_mem[c]) c++;
        if (heap_mem[c] <= k) break;
        heap_mem[i] = heap_mem[c];
        i = c;
      end
      heap_mem[i] = k;
    end
  endtask

  task automatic classify(input logic act, input data_t v, input logic lst,
                          output trace_result_t r);
    int t;
    if (!act) begin
      if (alive_f) begin
        if (fifo_cnt >= DEPTH) ovf = 1;
        else begin
          t = (fifo_head + fifo_cnt) % DEPTH;
          fifo_mem[t] = v;
          fifo_cnt++;
        end
      end
      if (alive_l) begin
        if (lifo_cnt >= DEPTH) ovf = 1;
        else begin
          lifo_mem[lifo_cnt] = v;
          lifo_cnt++;
        end
      end
      if (alive_h) begin
        if (heap_cnt >= DEPTH) ovf = 1;
        else heap_insert(v);
      end
    end else begin
      if (alive_f) begin
        if (fifo_cnt == 0 || fifo_mem[fifo_head] != v) alive_f = 0;
        else begin
          fifo_head = (fifo_head + 1) % DEPTH;
          fifo_cnt--;
        end
      end
      if (alive_l) begin
        if (lifo_cnt == 0 || lifo_mem[lifo_cnt - 1] != v) alive_l = 0;
        else lifo_cnt--;
      end
      if (alive_h) begin
        if (heap_cnt == 0 || heap_mem[0] != v) alive_h = 0;
        else heap_remove_top();
      end
    end
    r.fifo_ok = alive_f;
    r.lifo_ok = alive_l;
    r.heap_ok = alive_h;
    case ({alive_h, alive_l, alive_f})
      3'b000:  r.verdict = V_IMPOSSIBLE;
      3'b001:  r.verdict = V_QUEUE;
      3'b010:  r.verdict = V_STACK;
      3'b100:  r.verdict = V_PRIORITY;
      default: r.verdict = V_NOT_SURE;
    endcase
    r.overflow = ovf;
    r.case_end = lst;
    if (lst) begin
      if (ovf) overflow_cases++;
      clear_trace();
    end
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    overflow_cases = 0;
    clear_trace();
  end

  assign pending = expected_results.size();

  always @(posedge clk) begin
    trace_result_t e, a;
    if (!rst) begin
      if (req.valid && req.ready) begin
        classify(req.action, req.value, req.last, e);
        expected_results.push_back(e);
      end
      if (rsp.valid && rsp.ready) begin
        a.fifo_ok  = rsp.fifo_ok;
        a.lifo_ok  = rsp.lifo_ok;
        a.heap_ok  = rsp.heap_ok;
        a.verdict  = verdict_t'(rsp.verdict);
        a.overflow = rsp.overflow;
        a.case_end = rsp.case_end;
        result_count++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result beat %0d with nothing expected", result_count);
        end else begin
          e = expected_results.pop_front();
          if (a !== e) begin
            fail_count++;
            if (fail_count <= 10)
              $display("beat %0d: exp f%b l%b h%b v%0d o%b e%b, got f%b l%b h%b v%0d o%b e%b",
                       result_count, e.fifo_ok, e.lifo_ok, e.heap_ok, e.verdict, e.overflow,
                       e.case_end, a.fifo_ok, a.lifo_ok, a.heap_ok, a.verdict, a.overflow,
                       a.case_end);
          end
        end
      end
    end
  end
endmodule

// ----- test/testbench.sv -----
// Top of the trace classifier testbench: clock, reset, operation stimulus, result
// back-pressure and verdict. Depends on tlc_pkg, tlc_ifs, tlc_checker and the block.
`timescale 1ns / 100ps
module testbench;
  import tlc_pkg::*;

  typedef enum int { K_QUEUE, K_STACK, K_HEAP, K_NOISE } trace_kind_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_LEN    = 400;

  logic clk, rst;
  int   fails, pending, results, ovf_cases;
  int   cycles, items_sent, cases_sent;
  bit   quiet;

  tlc_op_if  req();
  tlc_res_if rsp();

  fifo_lifo_heap_trace_classifier_top i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  tlc_checker i_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .fail_count(fails), .pending(pending),
    .result_count(results), .overflow_cases(ovf_cases)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // result side: random stalls, one long hold-off
  initial begin
    int  gap;
    bit  held;
    held = 0;
    rsp.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results >= HOLD_AT) begin
        held = 1;
        gap = HOLD_LEN;
      end else gap = draw_gap();
      if (gap > 0) begin
        rsp.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_op(logic act, data_t v, logic lst);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req.valid  <= 1;
    req.action <= act;
    req.value  <= v;
    req.last   <= lst;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (lst) cases_sent++;
  endtask

  function automatic data_t rand_value();
    case ($urandom_range(0, 9))
      0:       return data_t'($urandom);
      1:       return data_t'(32'h7fffffff);
      2:       return data_t'(32'h80000000);
      3:       return -data_t'($urandom_range(0, 7));
      default: return data_t'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic random_trace();
    trace_kind_t kind;
    data_t       shadow[$];
    data_t       v;
    int          len, best;
    logic        act;
    kind = trace_kind_t'($urandom_range(0, 3));
    len = $urandom_range(1, 16);
    for (int n = 0; n < len; n++) begin
      if (kind == K_NOISE) begin
        act = 1'($urandom_range(0, 1));
        v = rand_value();
      end else if (shadow.size() == 0 || $urandom_range(0, 1)) begin
        act = 0;
        v = rand_value();
        shadow.push_back(v);
      end else begin
        act = 1;
        case (kind)
          K_QUEUE: v = shadow.pop_front();
          K_STACK: v = shadow.pop_back();
          default: begin
            best = 0;
            foreach (shadow[j]) if (shadow[j] > shadow[best]) best = j;
            v = shadow[best];
            shadow.delete(best);
          end
        endcase
        if ($urandom_range(0, 9) == 0) v = v + 1;
      end
      if (kind != K_NOISE && act && shadow.size() == 0 && $urandom_range(0, 7) == 0)
        v = rand_value();
      send_op(act, v, n == len - 1);
    end
  endtask

  initial begin
    cycles = 0;
    items_sent = 0;
    cases_sent = 0;
    quiet = 0;
    rst = 1;
    req.valid = 0;
    req.action = 0;
    req.value = '0;
    req.last = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // pop from an empty trace
    send_op(1'b1, 0, 1'b1);
    // extremes, heap order on signed values
    send_op(1'b0, data_t'(32'h80000000), 1'b0);
    send_op(1'b0, data_t'(32'h7fffffff), 1'b0);
    send_op(1'b0, -1, 1'b0);
    send_op(1'b0, 0, 1'b0);
    send_op(1'b1, data_t'(32'h7fffffff), 1'b0);
    send_op(1'b1, 0, 1'b0);
    send_op(1'b1, -1, 1'b0);
    send_op(1'b1, data_t'(32'h80000000), 1'b1);
    // queue only, then stack only
    send_op(1'b0, 5, 1'b0);
    send_op(1'b0, 9, 1'b0);
    send_op(1'b1, 5, 1'b0);
    send_op(1'b1, 9, 1'b1);
    send_op(1'b0, 3, 1'b0);
    send_op(1'b0, 1, 1'b0);
    send_op(1'b1, 1, 1'b0);
    send_op(1'b1, 3, 1'b1);
    // ruled out everywhere, further ops ignored
    send_op(1'b0, 2, 1'b0);
    send_op(1'b1, 7, 1'b0);
    send_op(1'b0, 4, 1'b0);
    send_op(1'b1, 4, 1'b1);

    while (items_sent < 450) begin
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      random_trace();
    end
    req.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d operations in %0d cases, %0d results checked, %0d cases overflowed",
             items_sent, cases_sent, results, ovf_cases);
    if (fails == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", fails);
      $display("testbench failed");
    end
    $finish;
  end
endmodule
